// ===== rtl/mfvc_pkg.sv =====
// mfvc_pkg: shared constants, types and the fold test of the mesh fold check
// used by the core and the result fifo; no dependencies

package mfvc_pkg;

    localparam int MAX_WIDTH   = 32;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int COORD_BITS  = 32;
    localparam int ROW_W       = 16;
    localparam int MW_W        = 6;
    localparam int OUT_DEPTH   = 4;
    localparam int CNT_W       = $clog2(OUT_DEPTH + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 2 * COORD_BITS;
    localparam int RES_BITS    = 1 + COL_W + ROW_W;
    localparam int OUT_DATA_W  = ((RES_BITS + 7) / 8) * 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MESH_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MESH_HEIGHT = 2'd1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [COL_W:0]               t_weff;

    // one column of the line buffer
    typedef struct packed {
        t_coord old_y;
        logic   v;
        t_coord y;
        t_coord x;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic             last;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             ok;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

    // work item travelling from read issue to evaluate stage
    typedef struct packed {
        logic             is_drain;
        logic             emit;
        logic             first_col;
        logic             last_col;
        logic             row_one;
        logic             last;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row_out;
        logic             v_new;
        t_coord           y_new;
        t_coord           x_new;
    } t_slot;

    // (a - m) * (m - b) < 0, from the order of the three values
    function automatic logic folds(input t_coord a, input t_coord m, input t_coord b);
        return ((a > m) && (m < b)) || ((a < m) && (m > b));
    endfunction

endpackage

// ===== rtl/mesh_fold_validity_check_core.sv =====
// mesh_fold_validity_check_core: top level of the mesh fold check
// depends on mfvc_pkg, mfvc_ram and mfvc_out_fifo

// usage
//   slave stream takes projected mesh nodes in raster order (row 0 first,
//   column 0 first within a row); tdata = {node_y, node_x}, tuser = node_valid
//   master stream gives one fold result per node; tdata = {out_row, out_col,
//   node_ok}, tlast marks the final result caused by one input transaction
//   config channel writes mesh_width (index 0) and mesh_height (index 1);
//   only write it while the block is idle
// throughput
//   one node accepted per cycle while the result queue has room and no drain
//   runs; the result for node (c, r-1) comes from the slot of node (c, r)
//   and is queued in the result fifo, so results trail one row behind; the
//   last node of a mesh starts a drain of the final row: the line buffer is
//   read once per column and no input is taken, then the next mesh starts at row 0
//   the pace is set by the line buffer ram: one read and one write per cycle
// reset
//   counters return to column 0, row 0, width and height to 3; the line
//   buffer is not cleared since every entry is written before its value is used
// stall
//   results queue in a 4-entry fifo; the slave side holds tready low once
//   the queue plus the result in flight could fill it

module mesh_fold_validity_check_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [mfvc_pkg::IN_DATA_W-1:0]     i_s_tdata,   // node_x[31:0], node_y[63:32]
    input  logic                               i_s_tuser,   // node_valid
    // master stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [mfvc_pkg::OUT_DATA_W-1:0]    o_m_tdata,   // node_ok[0], out_col[5:1], out_row[21:6]
    output logic                               o_m_tlast,   // last_of_run
    // config write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mfvc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mfvc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import mfvc_pkg::*;

    // configuration registers
    logic [MW_W-1:0]  r_mesh_width;
    logic [ROW_W-1:0] r_mesh_height;

    // position of the next input node
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    // final row drain
    logic             r_drain_act;
    logic [COL_W-1:0] r_drain_col;
    logic [ROW_W-1:0] r_drain_row;

    // evaluate stage
    logic             r_s1_vld;
    t_slot            r_s1;
    t_coord           r_left_x;

    // effective mesh size
    t_weff            w_weff;
    logic [ROW_W-1:0] w_heff;

    // issue stage
    logic             w_wrap;
    logic [COL_W-1:0] w_c;
    logic [ROW_W-1:0] w_r;
    logic             w_last_col_in;
    logic [ROW_W:0]   w_row_inc;
    logic             w_mesh_end;
    logic             w_drain_last;
    logic             w_space;
    logic             w_in_acc;
    logic             w_drain_iss;
    logic             w_issue;
    logic [COL_W-1:0] w_rd_col;
    logic [COL_W-1:0] w_nxt_col;
    t_slot            n_slot;

    // evaluate stage datapath
    t_entry           w_rd_entry;
    logic [COORD_BITS-1:0] w_rd_right;
    t_coord           w_cx;
    t_coord           w_cy;
    t_coord           w_lx;
    t_coord           w_rx;
    t_coord           w_ty;
    logic             w_h_bad;
    logic             w_v_bad;
    logic             w_push;
    t_result          w_push_data;
    t_entry           w_wr_entry;
    logic             w_wr_en;

    // result queue
    logic [CNT_W-1:0] w_fifo_cnt;
    t_result          w_out;

    assign o_cfg_ready = 1'b1;

    // clamp width to 3..MAX_WIDTH, height to at least 3
    always_comb begin
        if (r_mesh_width < MW_W'(3)) begin
            w_weff = t_weff'(3);
        end else if (int'(r_mesh_width) > MAX_WIDTH) begin
            w_weff = t_weff'(MAX_WIDTH);
        end else begin
            w_weff = t_weff'(r_mesh_width);
        end
        w_heff = (r_mesh_height < ROW_W'(3)) ? ROW_W'(3) : r_mesh_height;
    end

    // a counter left outside the mesh by a config write restarts the mesh
    assign w_wrap        = ({1'b0, r_col} >= w_weff) || (r_row >= w_heff);
    assign w_c           = w_wrap ? '0 : r_col;
    assign w_r           = w_wrap ? '0 : r_row;
    assign w_last_col_in = ({1'b0, w_c} == (w_weff - t_weff'(1)));
    assign w_row_inc     = {1'b0, w_r} + (ROW_W + 1)'(1);
    assign w_mesh_end    = w_last_col_in && (w_row_inc >= {1'b0, w_heff});
    assign w_drain_last  = ({1'b0, r_drain_col} == (w_weff - t_weff'(1)));

    // room for the result of the slot in flight and of a new one
    assign w_space     = ((CNT_W + 1)'(w_fifo_cnt) + (CNT_W + 1)'(r_s1_vld && r_s1.emit))
                         < (CNT_W + 1)'(OUT_DEPTH);
    assign o_s_tready  = !r_drain_act && w_space;
    assign w_in_acc    = i_s_tvalid && o_s_tready;
    assign w_drain_iss = r_drain_act && w_space;
    assign w_issue     = w_in_acc || w_drain_iss;

    // column of the slot, and its right neighbour for the shadow x ram
    assign w_rd_col  = r_drain_act ? r_drain_col : w_c;
    assign w_nxt_col = w_rd_col + COL_W'(1);

    always_comb begin
        n_slot = '0;
        if (r_drain_act) begin
            n_slot.is_drain  = 1'b1;
            n_slot.emit      = 1'b1;
            n_slot.first_col = (r_drain_col == '0);
            n_slot.last_col  = w_drain_last;
            n_slot.row_one   = 1'b0;
            n_slot.last      = w_drain_last;
            n_slot.col       = r_drain_col;
            n_slot.row_out   = r_drain_row;
        end else begin
            n_slot.is_drain  = 1'b0;
            n_slot.emit      = (w_r != '0);
            n_slot.first_col = (w_c == '0);
            n_slot.last_col  = w_last_col_in;
            n_slot.row_one   = (w_r == ROW_W'(1));
            // the final node hands tlast over to the drain
            n_slot.last      = !w_mesh_end;
            n_slot.col       = w_c;
            n_slot.row_out   = w_r - ROW_W'(1);
            n_slot.v_new     = i_s_tuser;
            n_slot.y_new     = t_coord'(i_s_tdata[IN_DATA_W-1:COORD_BITS]);
            n_slot.x_new     = t_coord'(i_s_tdata[COORD_BITS-1:0]);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mesh_width  <= MW_W'(3);
            r_mesh_height <= ROW_W'(3);
            r_col         <= '0;
            r_row         <= '0;
            r_drain_act   <= 1'b0;
            r_drain_col   <= '0;
            r_s1_vld      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_MESH_WIDTH: begin
                        r_mesh_width <= i_cfg_data[MW_W-1:0];
                    end
                    REG_MESH_HEIGHT: begin
                        r_mesh_height <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (w_in_acc) begin
                if (w_last_col_in) begin
                    r_col <= '0;
                    r_row <= w_mesh_end ? '0 : w_row_inc[ROW_W-1:0];
                end else begin
                    r_col <= w_c + COL_W'(1);
                    r_row <= w_r;
                end
                if (w_mesh_end) begin
                    r_drain_act <= 1'b1;
                    r_drain_col <= '0;
                end
            end
            if (w_drain_iss) begin
                if (w_drain_last) begin
                    r_drain_act <= 1'b0;
                end else begin
                    r_drain_col <= r_drain_col + COL_W'(1);
                end
            end
            r_s1_vld <= w_issue;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_mesh_end) begin
            r_drain_row <= w_r;
        end
        if (w_issue) begin
            r_s1 <= n_slot;
        end
        if (r_s1_vld) begin
            r_left_x <= w_cx;
        end
    end

    // line buffer: full column entry, plus a copy of x read one column ahead
    mfvc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_s1.col),
        .i_wr_data (w_wr_entry),
        .i_rd_addr (w_rd_col),
        .o_rd_data (w_rd_entry)
    );

    mfvc_ram #(
        .WIDTH (COORD_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_right_x_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_s1.col),
        .i_wr_data (r_s1.x_new),
        .i_rd_addr (w_nxt_col),
        .o_rd_data (w_rd_right)
    );

    // evaluate: edges use the node itself as the missing neighbour
    assign w_cx = w_rd_entry.x;
    assign w_cy = w_rd_entry.y;
    assign w_lx = r_s1.first_col ? w_cx : r_left_x;
    assign w_rx = r_s1.last_col ? w_cx : t_coord'(w_rd_right);
    assign w_ty = r_s1.row_one ? w_cy : w_rd_entry.old_y;

    assign w_h_bad = folds(w_rx, w_cx, w_lx);
    // bottom row in the drain is its own bottom neighbour, so it never folds in y
    assign w_v_bad = !r_s1.is_drain && folds(w_ty, w_cy, r_s1.y_new);

    assign w_push           = r_s1_vld && r_s1.emit;
    assign w_push_data.ok   = w_rd_entry.v && !w_h_bad && !w_v_bad;
    assign w_push_data.col  = r_s1.col;
    assign w_push_data.row  = r_s1.row_out;
    assign w_push_data.last = r_s1.last;

    // write back: the y read moves to the older slot, the new node takes its place
    assign w_wr_en          = r_s1_vld && !r_s1.is_drain;
    assign w_wr_entry.old_y = w_cy;
    assign w_wr_entry.v     = r_s1.v_new;
    assign w_wr_entry.y     = r_s1.y_new;
    assign w_wr_entry.x     = r_s1.x_new;

    mfvc_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_count     (w_fifo_cnt),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_data      (w_out)
    );

    assign o_m_tdata = OUT_DATA_W'(w_out[RESULT_W-2:0]);
    assign o_m_tlast = w_out.last;

    // result queue never overflows
    a_fifo_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> ((w_fifo_cnt < CNT_W'(OUT_DEPTH)) || (o_m_tvalid && i_m_tready)))
        else $error("result queue overflow");

    // drain starts only after the node in the last column is accepted
    a_drain_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_drain_act) |-> $past(w_in_acc && w_last_col_in))
        else $error("drain started without final node");

    // drain slots never write the line buffer
    a_drain_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1.is_drain) |-> !w_wr_en)
        else $error("line buffer written by drain");

endmodule

// ===== rtl/mfvc_ram.sv =====
// mfvc_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies

module mfvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/mfvc_out_fifo.sv =====
// mfvc_out_fifo: small result queue in front of the output stream
// depends on mfvc_pkg

module mfvc_out_fifo (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  mfvc_pkg::t_result         i_push_data,
    output logic [mfvc_pkg::CNT_W-1:0] o_count,
    output logic                      o_valid,
    input  logic                      i_ready,
    output mfvc_pkg::t_result         o_data
);
    import mfvc_pkg::*;

    localparam int PTR_W = $clog2(OUT_DEPTH);

    t_result          r_mem [OUT_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_pop;

    assign o_valid = (r_count != '0);
    assign w_pop   = o_valid && i_ready;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && w_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule
